/* rtl/core/cmpa_pkg.sv */
// ----------------------------------------------------------------------------
// cmpa_pkg
// Types and codes shared by the compacting arena allocator RTL.
// ----------------------------------------------------------------------------
package cmpa_pkg;

  localparam int unsigned SlotW = 4;
  localparam int unsigned LenW  = 16;
  localparam int unsigned FmtW  = 4;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  typedef enum logic [1:0] {
    CmdReserve   = 2'd0,
    CmdRemove    = 2'd1,
    CmdLookup    = 2'd2,
    CmdClearFill = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatRejected = 2'd1,
    StatBadSlot  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StLook  = 2'd1,
    StSweep = 2'd2
  } state_e;

  // register word index (paddr[2])
  localparam logic RegCapacity = 1'b0;

  typedef struct packed {
    cmd_e              cmd;
    logic [SlotW-1:0]  slot;
    logic [LenW-1:0]   req_length;
    logic [FmtW-1:0]   req_format;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [LenW-1:0]   block_offset;
    logic [LenW-1:0]   block_length;
    logic [FmtW-1:0]   block_format;
    logic              move_needed;
    logic [LenW-1:0]   move_source;
    logic [LenW-1:0]   move_dest;
    logic [LenW-1:0]   move_length;
    logic [LenW-1:0]   fill_count;
  } rsp_t;

endpackage

/* rtl/core/compacting_arena_allocator.sv */
// ----------------------------------------------------------------------------
// compacting_arena_allocator
// Slot table over a bottom-up byte arena: reserve, remove with compaction,
// lookup and fill reset. Reports the tail copy a remove leaves behind.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on req_i, taken when start is high and busy is low.
//   Each command gives exactly one result beat on result_o, marked by a
//   single-cycle done_o; the receiver cannot stall and must take it.
//   Reserve, lookup, fill reset and a remove of a bad slot finish from the
//   look state; a remove that compacts first runs the offset sweep, which
//   visits one slot per cycle through the offset memory's read port, write
//   port and single subtractor. busy drops in the done_o cycle, so a new
//   command may be taken there; none is taken while one is in progress.
//   arena_capacity is written over the APB port at byte address 0; the user
//   must write it only while busy is low; the block does not enforce this.
//   Reset clears capacity, fill count and all slot valid bits; slot contents
//   need no clearing pass.
// ----------------------------------------------------------------------------
module compacting_arena_allocator import cmpa_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              done_o,
  output rsp_t              result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_we;
  logic   done_q, done_d;

  logic [LenW-1:0] capacity;
  logic [LenW-1:0] fill_q, fill_d;
  logic [SLOTS-1:0] valid_q;
  logic             valid_set, valid_clr;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [LenW-1:0] roff_q, rlen_q;
  logic            sweep_load;

  // slot memories
  logic [LenW-1:0] off_mem [SLOTS];
  logic [LenW-1:0] len_mem [SLOTS];
  logic [FmtW-1:0] fmt_mem [SLOTS];
  logic [LenW-1:0] off_rd_q, len_rd_q;
  logic [FmtW-1:0] fmt_rd_q;
  logic [IdxW-1:0] raddr;
  logic            off_we, slot_we;
  logic [IdxW-1:0] off_waddr;
  logic [LenW-1:0] off_wdata;

  logic            accept;
  logic [IdxW-1:0] slot_idx;
  logic            in_range;
  logic            usable;
  logic            reserve_bad;
  logic [LenW-1:0] tail;
  logic [LenW-1:0] tail_len;
  logic            shift_hit;

  cmpa_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  assign slot_idx = IdxW'(req_q.slot);
  assign in_range = ({{(32-SlotW){1'b0}}, req_q.slot} < 32'(SLOTS));
  assign usable   = in_range && valid_q[slot_idx] &&
                    (({1'b0, off_rd_q} + {1'b0, len_rd_q}) <= {1'b0, fill_q});
  assign reserve_bad = (req_q.req_length == '0) || (req_q.req_format == '0) ||
                       !in_range || valid_q[slot_idx] || (fill_q > capacity) ||
                       (req_q.req_length > (capacity - fill_q));
  // usable guarantees offset+length fits below the fill point
  assign tail      = off_rd_q + len_rd_q;
  assign tail_len  = fill_q - tail;
  assign shift_hit = (idx_q != slot_idx) && valid_q[idx_q] && (off_rd_q > roff_q);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    rsp_d      = rsp_q;
    rsp_we     = 1'b0;
    done_d     = 1'b0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    sweep_load = 1'b0;
    raddr      = IdxW'(req_i.slot);
    off_we     = 1'b0;
    slot_we    = 1'b0;
    off_waddr  = slot_idx;
    off_wdata  = fill_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLook;
        end
      end
      StLook: begin
        rsp_we  = 1'b1;
        rsp_d   = '0;
        state_d = StIdle;
        done_d  = 1'b1;
        case (req_q.cmd)
          CmdReserve: begin
            if (reserve_bad) begin
              rsp_d.status = StatRejected;
            end else begin
              valid_set          = 1'b1;
              off_we             = 1'b1;
              slot_we            = 1'b1;
              rsp_d.block_offset = fill_q;
              fill_d             = fill_q + req_q.req_length;
            end
          end
          CmdRemove: begin
            if (!usable) begin
              valid_clr    = in_range;
              rsp_d.status = StatBadSlot;
            end else begin
              valid_clr  = 1'b1;
              sweep_load = 1'b1;
              fill_d     = fill_q - len_rd_q;
              if (tail_len != '0) begin
                rsp_d.move_needed = 1'b1;
                rsp_d.move_source = tail;
                rsp_d.move_dest   = off_rd_q;
                rsp_d.move_length = tail_len;
              end
              idx_d   = '0;
              raddr   = '0;
              done_d  = 1'b0;
              state_d = StSweep;
            end
          end
          CmdLookup: begin
            if (!usable) begin
              rsp_d.status = StatBadSlot;
            end else begin
              rsp_d.block_offset = off_rd_q;
              rsp_d.block_length = len_rd_q;
              rsp_d.block_format = fmt_rd_q;
            end
          end
          CmdClearFill: begin
            fill_d = '0;
          end
          default: begin
            rsp_d.status = StatRejected;
          end
        endcase
        rsp_d.fill_count = fill_d;
      end
      StSweep: begin
        // offset of slot idx_q is on the read port; fetch the next one meanwhile
        off_we    = shift_hit;
        off_waddr = idx_q;
        off_wdata = off_rd_q - rlen_q;
        raddr     = idx_q + 1'b1;
        idx_d     = idx_q + 1'b1;
        if (idx_q == IdxW'(SLOTS - 1)) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      if (valid_set) begin
        valid_q[slot_idx] <= 1'b1;
      end else if (valid_clr) begin
        valid_q[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (rsp_we) begin
      rsp_q <= rsp_d;
    end
    if (sweep_load) begin
      roff_q <= off_rd_q;
      rlen_q <= len_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    if (slot_we) begin
      len_mem[slot_idx] <= req_q.req_length;
      fmt_mem[slot_idx] <= req_q.req_format;
    end
    off_rd_q <= off_mem[raddr];
    len_rd_q <= len_mem[raddr];
    fmt_rd_q <= fmt_mem[raddr];
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one beat");

  a_move_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.move_needed |-> result_o.status == StatOk &&
      result_o.move_length != '0) else $error("move reported on failed remove");

  a_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.move_needed |-> result_o.move_length == '0 &&
      result_o.move_source == '0 && result_o.move_dest == '0)
    else $error("move fields set without move");

  a_sweep_idle_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSweep && state_d == StSweep |=> $stable(fill_q))
    else $error("fill count changed during sweep");

endmodule

/* rtl/core/cmpa_apb_regs.sv */
// ----------------------------------------------------------------------------
// cmpa_apb_regs
// APB register slave holding the arena capacity.
// ----------------------------------------------------------------------------
module cmpa_apb_regs import cmpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [LenW-1:0]   capacity_o
);

  logic [LenW-1:0] cap_q, cap_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegCapacity);

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else begin
      cap_q <= cap_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegCapacity) begin
      prdata = {{(PdataW-LenW){1'b0}}, cap_q};
    end
  end

  assign capacity_o = cap_q;

endmodule
